// ===== rtl/pbf_pkg.sv =====
// ----------------------------------------------------------------------------
// pbf_pkg
// Types and constants used by the partitioned Bloom filter module.
// ----------------------------------------------------------------------------
package pbf_pkg;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [31:0] SEED_STEP = 32'd2654435761;

   localparam logic [1:0] CSR_NUM_PARTITIONS = 2'd0;
   localparam logic [1:0] CSR_WORDS          = 2'd1;
   localparam logic [1:0] CSR_NUM_HASHES     = 2'd2;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_PART,
      ST_REHASH_RD,
      ST_REHASH,
      ST_PROBE_IDX,
      ST_PROBE_RD,
      ST_PROBE_WAIT,
      ST_PROBE_CHK,
      ST_DONE
   } state_type;

   // One FNV-1a style step over a sign-extended byte.
   function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b,
                                            input logic [31:0] seed);
      logic [31:0] sx;
      sx = {{24{b[7]}}, b};
      return (h ^ (sx + seed)) * FNV_PRIME;
   endfunction

endpackage

// ===== rtl/partitioned_bloom_filter.sv =====
// ----------------------------------------------------------------------------
// partitioned_bloom_filter
// Partitioned Bloom filter over byte-streamed keys, FNV-1a style hashing.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                 | tuser | tlast
// req_    | in  | key_byte[7:0]                      | func  | last
// rsp_    | out | maybe_present, partition[3:0], ovf | -     | -
// csr_    | in  | we, index, 7-bit data              | -     | -
//
// Non-last bytes: hash update, key buffer write.
// Last byte: partition remainder by restoring division, rehash of the
// L-byte key, one probe per hash (index reduction, read wait, check),
// then report and rearm. An over-long key goes straight to report.
// After reset the bit store clears all MAX_PARTITIONS*MAX_WORDS words
// with req_tready low. A waiting response stalls only the report step.
// ----------------------------------------------------------------------------
module partitioned_bloom_filter #(
   parameter int MAX_PARTITIONS = 16,
   parameter int MAX_WORDS      = 64,
   parameter int MAX_KEY_BYTES  = 64,
   parameter int MAX_HASHES     = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // key_byte[7:0]
   input  logic       req_tuser,   // func
   input  logic       req_tlast,   // last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // maybe_present, partition[3:0], key_overflow, 0
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_wdata
);
   import pbf_pkg::*;

   localparam int DEPTH = MAX_PARTITIONS * MAX_WORDS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KW    = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int LW    = $clog2(MAX_KEY_BYTES + 1);
   localparam int HW    = $clog2(MAX_HASHES + 1);
   localparam int PW    = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
   localparam int WW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int NW    = $clog2(MAX_WORDS + 1);

   logic [4:0] np_ff, nh_ff;
   logic [6:0] nw_ff;
   logic [4:0] np_eff;
   logic [NW-1:0] nw_eff;
   logic [HW-1:0] nh_eff;

   // remainder by 3, one bit at a time from the top
   function automatic logic [1:0] mod3(input logic [PW-1:0] v);
      logic [2:0] t;
      logic [1:0] m;
      m = 2'd0;
      for (int i = PW - 1; i >= 0; i--) begin
         t = {m, v[i]};
         m = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
      end
      return m;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         np_ff <= 5'd1;
         nw_ff <= 7'd64;
         nh_ff <= 5'd4;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_PARTITIONS: np_ff <= csr_wdata[4:0];
            CSR_WORDS:          nw_ff <= csr_wdata;
            CSR_NUM_HASHES:     nh_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      np_eff = (np_ff == 5'd0) ? 5'd1 : np_ff;
      if (32'(np_eff) > MAX_PARTITIONS) np_eff = 5'(MAX_PARTITIONS);
      if (nw_ff == 7'd0) nw_eff = NW'(1);
      else if (32'(nw_ff) > MAX_WORDS) nw_eff = NW'(MAX_WORDS);
      else nw_eff = NW'(nw_ff);
      nh_eff = (32'(nh_ff) > MAX_HASHES) ? HW'(MAX_HASHES) : HW'(nh_ff);
   end

   // key buffer memory
   logic [7:0]    kmem [MAX_KEY_BYTES];
   logic [7:0]    kbyte_ff;
   logic [KW-1:0] krd;

   state_type     st_ff, st_in;
   logic [31:0]   h0_ff, h1_ff, h2_ff, h0_in, h1_in, h2_in;
   logic [LW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in, func_ff, func_in;
   logic [31:0]   rem_ff, rem_in;      // partition remainder
   logic [5:0]    rcnt_ff, rcnt_in;
   logic [31:0]   seed_ff, seed_in, h_ff, h_in;
   logic [LW-1:0] ri_ff, ri_in;
   logic [HW-1:0] pi_ff, pi_in;
   logic [63:0]   acc_ff, acc_in;      // h + i*seed
   logic [63:0]   idx_ff, idx_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          all_ff, all_in;
   logic [7:0]    rsp_ff, rsp_in;
   logic          rv_ff, rv_in;
   logic [NW+5:0] nbits;
   logic [63:0]   wdata;
   logic          wen;
   logic [63:0]   rd_data;
   logic          clear_busy;
   logic          acc;
   logic [31:0]   trial;
   logic [63:0]   step;

   assign acc   = req_tvalid & req_tready;
   assign nbits = {nw_eff, 6'd0};
   assign krd   = ri_in[KW-1:0];

   always_ff @(posedge clock) begin
      if (acc && len_ff < LW'(MAX_KEY_BYTES)) begin
         kmem[len_ff[KW-1:0]] <= req_tdata;
      end
      kbyte_ff <= kmem[krd];
   end

   pbf_bit_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock, .reset, .rd_addr(addr_ff), .rd_data,
      .wr_en(wen), .wr_addr(addr_ff), .wr_data(wdata), .clear_busy
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_COLLECT;
         h0_ff  <= FNV_BASIS;
         h1_ff  <= FNV_BASIS;
         h2_ff  <= FNV_BASIS;
         len_ff <= '0;
         ovf_ff <= 1'b0;
         rv_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         h0_ff  <= h0_in;
         h1_ff  <= h1_in;
         h2_ff  <= h2_in;
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         rv_ff  <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      rem_ff  <= rem_in;
      rcnt_ff <= rcnt_in;
      seed_ff <= seed_in;
      h_ff    <= h_in;
      ri_ff   <= ri_in;
      pi_ff   <= pi_in;
      acc_ff  <= acc_in;
      idx_ff  <= idx_in;
      addr_ff <= addr_in;
      all_ff  <= all_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      st_in = st_ff; h0_in = h0_ff; h1_in = h1_ff; h2_in = h2_ff;
      len_in = len_ff; ovf_in = ovf_ff; func_in = func_ff;
      rem_in = rem_ff; rcnt_in = rcnt_ff; seed_in = seed_ff; h_in = h_ff;
      ri_in = ri_ff; pi_in = pi_ff; acc_in = acc_ff; idx_in = idx_ff;
      addr_in = addr_ff; all_in = all_ff; rsp_in = rsp_ff; rv_in = rv_ff;
      wen = 1'b0; wdata = rd_data;
      trial = '0;
      step = '0;
      req_tready = 1'b0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (st_ff)
         ST_COLLECT: begin
            req_tready = !clear_busy;
            if (acc) begin
               func_in = req_tuser;
               if (len_ff < LW'(MAX_KEY_BYTES)) begin
                  len_in = len_ff + LW'(1);
                  h0_in = fnv_step(h0_ff, req_tdata, 32'd0);
                  h1_in = fnv_step(h1_ff, req_tdata, SEED_STEP);
                  h2_in = fnv_step(h2_ff, req_tdata, SEED_STEP << 1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  if (ovf_in) begin
                     // report present in partition 0, no probes
                     rem_in = '0; all_in = 1'b1; pi_in = nh_eff;
                     st_in  = ST_PROBE_IDX;
                  end else begin
                     rem_in = '0; rcnt_in = 6'd32;
                     st_in = ST_PART;
                  end
               end
            end
         end
         ST_PART: begin   // restoring division, one quotient bit a cycle
            trial = {rem_ff[30:0], h0_ff[rcnt_ff[4:0] - 5'd1]};
            rem_in = (trial >= 32'(np_eff)) ? trial - 32'(np_eff) : trial;
            rcnt_in = rcnt_ff - 6'd1;
            if (rcnt_ff == 6'd1) st_in = ST_REHASH_RD;
         end
         ST_REHASH_RD: begin
            unique case (mod3(rem_ff[PW-1:0]))
               2'd0: seed_in = h0_ff;
               2'd1: seed_in = h1_ff;
               default: seed_in = h2_ff;
            endcase
            h_in = FNV_BASIS; ri_in = '0;
            st_in = ST_REHASH;
         end
         ST_REHASH: begin
            h_in = fnv_step(h_ff, kbyte_ff, seed_ff);
            ri_in = ri_ff + LW'(1);
            if (ri_in == len_ff) begin
               pi_in = '0; all_in = 1'b1;
               acc_in = {32'd0, h_in};
               st_in = ST_PROBE_IDX;
            end
         end
         ST_PROBE_IDX: begin
            if (pi_ff == nh_eff) begin
               // hold until the previous response has left
               if (!rv_ff || rsp_tready) begin
                  rsp_in = {2'd0, ovf_ff, 4'(rem_ff), all_ff};
                  rv_in = 1'b1;
                  st_in = ST_DONE;
               end
            end else begin
               idx_in = acc_ff;
               rcnt_in = 6'd32;
               st_in = ST_PROBE_RD;
            end
         end
         ST_PROBE_RD: begin   // idx mod nbits: subtract nbits<<k for k = 32 down to 0
            step = 64'(nbits) << rcnt_ff;
            if (idx_ff >= step) idx_in = idx_ff - step;
            if (rcnt_ff == 6'd0) begin
               addr_in = AW'(rem_ff[PW-1:0]) * AW'(MAX_WORDS) + AW'(idx_in[WW+5:6]);
               st_in = ST_PROBE_WAIT;
            end else begin
               rcnt_in = rcnt_ff - 6'd1;
            end
         end
         ST_PROBE_WAIT: st_in = ST_PROBE_CHK;
         ST_PROBE_CHK: begin
            if (!rd_data[idx_ff[5:0]]) all_in = 1'b0;
            if (func_ff == FUNC_ADD) begin
               wen = 1'b1;
               wdata = rd_data | (64'd1 << idx_ff[5:0]);
            end
            pi_in = pi_ff + HW'(1);
            acc_in = acc_ff + {32'd0, seed_ff};
            st_in = ST_PROBE_IDX;
         end
         ST_DONE: begin
            h0_in = FNV_BASIS; h1_in = FNV_BASIS; h2_in = FNV_BASIS;
            len_in = '0; ovf_in = 1'b0;
            st_in = ST_COLLECT;
         end
         default: st_in = ST_COLLECT;
      endcase
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset) rv_ff && !rsp_tready |=> rv_ff)
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset) req_tready |-> st_ff == ST_COLLECT)
      else $error("request taken while busy");
   assert property (@(posedge clock) disable iff (reset) wen |-> st_ff == ST_PROBE_CHK)
      else $error("stray bit store write");

endmodule

// ===== rtl/pbf_bit_store.sv =====
// ----------------------------------------------------------------------------
// pbf_bit_store
// Filter bit memory: one 64-bit word per entry, registered read, one write
// port, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module pbf_bit_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   output logic          clear_busy
);
   logic [63:0]   mem [DEPTH];
   logic [AW:0]   clr_ff, clr_in;
   logic [AW-1:0] waddr;
   logic [63:0]   wdata;
   logic          we;

   assign clear_busy = (clr_ff != AW'(0) + (AW+1)'(DEPTH));
   assign clr_in     = clear_busy ? clr_ff + (AW+1)'(1) : clr_ff;
   assign we         = clear_busy | wr_en;
   assign waddr      = clear_busy ? clr_ff[AW-1:0] : wr_addr;
   assign wdata      = clear_busy ? 64'd0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data <= mem[rd_addr];
   end

   assert property (@(posedge clock) disable iff (reset) clear_busy |-> !wr_en)
      else $error("bit store written during clear sweep");
   assert property (@(posedge clock) disable iff (reset)
                    !clear_busy |=> !clear_busy)
      else $error("clear sweep restarted");
   assert property (@(posedge clock) disable iff (reset)
                    clear_busy |=> clr_ff == $past(clr_ff) + (AW+1)'(1))
      else $error("clear counter skipped");

endmodule
